// ===== design/csvt_pkg.sv =====
// Shared types and constants for the CSV quoted-field tokenizer.
// No dependencies; every design file but csvt_if imports this package.
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] SEP_RESET = 8'd44;

    localparam int RES_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] field_byte;
        logic       row_empty;
        logic       last;
    } t_result;

    typedef struct packed {
        logic quoted;
        logic quote_pending;
        logic field_is_empty;
        logic row_has_content;
    } t_state;

    localparam t_result RES_NONE = '{
        kind:       KIND_BYTE,
        field_byte: 8'd0,
        row_empty:  1'b0,
        last:       1'b0
    };

    localparam t_state ST_RESET = '{
        quoted:          1'b0,
        quote_pending:   1'b0,
        field_is_empty:  1'b1,
        row_has_content: 1'b0
    };

endpackage

// ===== design/csvt_if.sv =====
// Valid/ready channel interfaces for the tokenizer input and result beats.
// Depends on nothing; kept separate from csvt_pkg.
interface csvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] field_byte;
    logic       row_empty;
    logic       last;

    modport source (output valid, output kind, output field_byte, output row_empty,
                    output last, input ready);
    modport sink   (input valid, input kind, input field_byte, input row_empty,
                    input last, output ready);
endinterface

// ===== design/csv_quoted_field_tokenizer.sv =====
// CSV tokenizer top level: input register, byte decode, result queue.
// Depends on csvt_pkg, csvt_if, csvt_step and csvt_fifo.
//
// Takes one byte (or an end-of-input mark) per beat and emits field bytes,
// field ends, row ends and format errors, one result beat per cycle while
// the output is ready. With the output side ready, a byte is accepted every
// cycle while the queue has room; its results pass through the input
// register, then the result queue, before they are offered. A byte that
// follows a closing quote and is neither a quote, separator nor line end gives
// a format error plus the byte's own result, two result beats; the result
// queue (DEPTH entries) absorbs these and holds input unless it has room for
// them. The separator may be rewritten only while no beats are in flight.
module csv_quoted_field_tokenizer
    import csvt_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    csvt_in_if.sink           i_in,
    csvt_out_if.source        o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    r_sep;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_eoi;
    t_state        r_state;
    t_state        n_state;
    logic [1:0]    res_cnt;
    t_result       res0;
    t_result       res1;
    logic [CW-1:0] q_count;
    t_result       q_head;
    logic          go;
    logic          in_acc;
    logic          out_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_wr_en) begin
            r_sep <= i_cfg_wr_data;
        end
    end

    csvt_step u_step (
        .i_state   (r_state),
        .i_sep     (r_sep),
        .i_byte    (r_in_byte),
        .i_eoi     (r_in_eoi),
        .o_state   (n_state),
        .o_res_cnt (res_cnt),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    assign go      = r_in_valid &&
                     (({1'b0, q_count} + (CW+1)'(res_cnt)) <= (CW+1)'(DEPTH));
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_pop = o_out.valid && o_out.ready;

    assign i_in.ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_RESET;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    csvt_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (go ? res_cnt : 2'd0),
        .i_data0    (res0),
        .i_data1    (res1),
        .i_pop      (out_pop),
        .o_count    (q_count),
        .o_head     (q_head)
    );

    assign o_out.valid      = (q_count != '0);
    assign o_out.kind       = q_head.kind;
    assign o_out.field_byte = q_head.field_byte;
    assign o_out.row_empty  = q_head.row_empty;
    assign o_out.last       = q_head.last;

endmodule

// ===== design/csvt_step.sv =====
// Combinational decode of one input byte: next parser state and up to two results.
// Depends on csvt_pkg.
module csvt_step
    import csvt_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_sep,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    output t_state     o_state,
    output logic [1:0] o_res_cnt,
    output t_result    o_res0,
    output t_result    o_res1
);

    typedef struct packed {
        t_state  s;
        logic    emit;
        t_result r;
    } t_plain;

    function automatic t_plain plain_byte(t_state s, logic [7:0] b, logic [7:0] sep);
        t_plain p;
        p.s    = s;
        p.emit = 1'b1;
        p.r    = RES_NONE;
        if (b == CH_LF || b == CH_CR) begin
            p.r.kind      = KIND_ROW_END;
            p.r.row_empty = !s.row_has_content;
            p.s           = ST_RESET;
        end else begin
            p.s.row_has_content = 1'b1;
            if (b == sep) begin
                p.r.kind           = KIND_FIELD_END;
                p.s.field_is_empty = 1'b1;
            end else if (b == CH_QUOTE && s.field_is_empty) begin
                p.s.quoted         = 1'b1;
                p.s.field_is_empty = 1'b0;
                p.emit             = 1'b0;
            end else begin
                p.r.kind           = KIND_BYTE;
                p.r.field_byte     = b;
                p.s.field_is_empty = 1'b0;
            end
        end
        return p;
    endfunction

    t_plain     p_cur;
    t_plain     p_close;
    t_plain     p_fresh;
    t_state     st;
    t_result    r0;
    t_result    r1;
    logic [1:0] cnt;

    always_comb begin
        t_state s_close;
        s_close               = i_state;
        s_close.quoted        = 1'b0;
        s_close.quote_pending = 1'b0;
        p_cur   = plain_byte(i_state, i_byte, i_sep);
        p_close = plain_byte(s_close, i_byte, i_sep);
        p_fresh = plain_byte(ST_RESET, i_byte, i_sep);
    end

    always_comb begin
        st  = i_state;
        r0  = RES_NONE;
        r1  = RES_NONE;
        cnt = 2'd0;
        if (i_eoi) begin
            st = ST_RESET;
            if (i_state.quoted && !i_state.quote_pending) begin
                r0.kind = KIND_ERROR;
                cnt     = 2'd1;
            end else if (i_state.row_has_content) begin
                r0.kind = KIND_ROW_END;
                cnt     = 2'd1;
            end
        end else if (i_state.quote_pending) begin
            if (i_byte == CH_QUOTE) begin
                r0.kind          = KIND_BYTE;
                r0.field_byte    = CH_QUOTE;
                cnt              = 2'd1;
                st.quote_pending = 1'b0;
            end else if (i_byte == i_sep || i_byte == CH_LF || i_byte == CH_CR) begin
                st  = p_close.s;
                r0  = p_close.r;
                cnt = {1'b0, p_close.emit};
            end else begin
                // bad byte after a closing quote: error, then byte opens a fresh row
                r0.kind = KIND_ERROR;
                r1      = p_fresh.r;
                st      = p_fresh.s;
                cnt     = p_fresh.emit ? 2'd2 : 2'd1;
            end
        end else if (i_state.quoted) begin
            st.row_has_content = 1'b1;
            if (i_byte == CH_QUOTE) begin
                st.quote_pending = 1'b1;
            end else begin
                r0.kind       = KIND_BYTE;
                r0.field_byte = i_byte;
                cnt           = 2'd1;
            end
        end else begin
            st  = p_cur.s;
            r0  = p_cur.r;
            cnt = {1'b0, p_cur.emit};
        end
        r0.last = (cnt == 2'd1);
        r1.last = 1'b1;
    end

    assign o_state   = st;
    assign o_res_cnt = cnt;
    assign o_res0    = r0;
    assign o_res1    = r1;

endmodule

// ===== design/csvt_fifo.sv =====
// Result queue: takes zero, one or two results per cycle, drains one per cycle when popped.
// Depends on csvt_pkg. DEPTH must be a power of two, at least 2.
module csvt_fifo
    import csvt_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  t_result                    i_data0,
    input  t_result                    i_data1,
    input  logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_result                    o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   wp_1;

    assign wp_1 = PW'(r_wp + PW'(1));

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp_1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= PW'(r_wp + PW'(i_push_cnt));
            r_rp    <= PW'(r_rp + PW'(i_pop));
            r_count <= CW'(r_count + CW'(i_push_cnt) - CW'(i_pop));
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_rp];

endmodule

// ===== design/csvt_checker.sv =====
// Port-level checks for the CSV tokenizer, attached to the top level by bind.
// Depends on csvt_pkg and csv_quoted_field_tokenizer.
module csvt_checker
    import csvt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_kind,
    input logic [7:0] i_out_field_byte,
    input logic       i_out_row_empty,
    input logic       i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_field_byte) &&
            $stable(i_out_row_empty) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_BYTE |-> i_out_field_byte == 8'd0)
        else $error("field_byte set on a non-byte result");

    a_row_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_row_empty |-> i_out_kind == KIND_ROW_END)
        else $error("row_empty set on a result other than row end");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind csv_quoted_field_tokenizer csvt_checker u_csvt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.kind),
    .i_out_field_byte (o_out.field_byte),
    .i_out_row_empty  (o_out.row_empty),
    .i_out_last       (o_out.last)
);
